### design/uv_disparity_line_matcher_macros.svh
// ----------------------------------------------------------------------------
// UV disparity line matcher assertion macros
// Concurrent assertion helpers, active only outside synthesis.
// ----------------------------------------------------------------------------
`ifndef UV_DISPARITY_LINE_MATCHER_MACROS_SVH
`define UV_DISPARITY_LINE_MATCHER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk and disabled during rst.
`define UVDLM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("uvdlm assertion failed");
// Next-cycle implication, sampled on clk and disabled during rst.
`define UVDLM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("uvdlm assertion failed");
`else
`define UVDLM_ASSERT_NOW(label, ante, cons)
`define UVDLM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### design/uvdlm_pkg.sv
// ----------------------------------------------------------------------------
// UV disparity line matcher package
// Shared widths, command codes, table entry type and the column mirror.
// ----------------------------------------------------------------------------
`default_nettype none
package uvdlm_pkg;

  localparam int unsigned FIELD_W     = 12;
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned RESULT_LIMIT = 32;
  localparam int unsigned MATCH_CNT_W = $clog2(RESULT_LIMIT + 1);

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DISPARITY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_TOLERANCE = 2'd2;

  localparam logic [FIELD_W-1:0] IMAGE_WIDTH_RST     = 12'd640;
  localparam logic [FIELD_W-1:0] MIN_DISPARITY_RST   = 12'd640;
  localparam logic [FIELD_W-1:0] MATCH_TOLERANCE_RST = 12'd160;

  // One stored U line.
  typedef struct packed {
    logic [FIELD_W-1:0] disparity;
    logic [FIELD_W-1:0] start_col;
    logic [FIELD_W-1:0] end_col;
  } line_t;

  localparam int unsigned LINE_W = $bits(line_t);

  // Mirror a column about the image width, saturating at zero.
  function automatic logic [FIELD_W-1:0] mirror_col(input logic [FIELD_W-1:0] width,
                                                   input logic [FIELD_W-1:0] col);
    mirror_col = (width > col) ? (width - col) : '0;
  endfunction

endpackage
`default_nettype wire

### design/uvdlm_cmd_if.sv
// ----------------------------------------------------------------------------
// UV disparity line matcher command channel
// Valid/ready channel carrying one clear, add or query command.
// ----------------------------------------------------------------------------
`default_nettype none
interface uvdlm_cmd_if;
  import uvdlm_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [FIELD_W-1:0] disparity;
  logic [FIELD_W-1:0] first_coord;
  logic [FIELD_W-1:0] second_coord;

  modport source (output valid, command, disparity, first_coord, second_coord,
                  input ready);
  modport sink (input valid, command, disparity, first_coord, second_coord,
                output ready);
endinterface
`default_nettype wire

### design/uvdlm_result_if.sv
// ----------------------------------------------------------------------------
// UV disparity line matcher result channel
// Valid/ready channel carrying one obstacle rectangle or an empty result.
// ----------------------------------------------------------------------------
`default_nettype none
interface uvdlm_result_if;
  import uvdlm_pkg::*;

  logic               valid;
  logic               ready;
  logic               found;
  logic [FIELD_W-1:0] left_x;
  logic [FIELD_W-1:0] top_y;
  logic [FIELD_W-1:0] right_x;
  logic [FIELD_W-1:0] bottom_y;
  logic               last;

  modport source (output valid, found, left_x, top_y, right_x, bottom_y, last,
                  input ready);
  modport sink (input valid, found, left_x, top_y, right_x, bottom_y, last,
                output ready);
endinterface
`default_nettype wire

### design/uvdlm_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
`default_nettype none
module uvdlm_ram #(
  parameter int unsigned WIDTH = 36,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### design/uvdlm_match.sv
// ----------------------------------------------------------------------------
// UV disparity line matcher compare unit
// Decides whether a stored U line lies strictly within tolerance of a query.
// ----------------------------------------------------------------------------
`default_nettype none
module uvdlm_match (
  input  wire logic [uvdlm_pkg::FIELD_W-1:0] line_disparity,
  input  wire logic [uvdlm_pkg::FIELD_W-1:0] query_disparity,
  input  wire logic [uvdlm_pkg::FIELD_W-1:0] tolerance,
  output logic                               hit
);
  import uvdlm_pkg::*;

  logic [FIELD_W-1:0] diff;

  // Absolute difference of two unsigned codes, then a strict compare.
  always_comb begin
    diff = (query_disparity > line_disparity) ? (query_disparity - line_disparity)
                                              : (line_disparity - query_disparity);
    hit  = (diff < tolerance);
  end

endmodule
`default_nettype wire

### design/uv_disparity_line_matcher.sv
// ----------------------------------------------------------------------------
// UV disparity line matcher
// Stores U-view lines in a RAM and scans them against V-view query lines.
// ----------------------------------------------------------------------------
// A clear or add command is taken while idle and gives no result. A query
// whose disparity is at or above min_disparity scans the stored lines in
// table order, reading one entry per cycle from the table RAM's read port
// while the scan is not stalled; no further command is taken until the
// query's final result enters the output register. Each match gives one
// rectangle; a query with no match, or below the minimum disparity, gives
// a single result with found low. The final result of every query carries
// last high, and at most 32 results are given per query. The scan pauses for
// as long as the result channel holds back a transfer while a second match is
// waiting. The next command can be taken while the final result of a query
// still waits in the output register. The table needs no clearing pass after
// reset: only entries below the line count are ever read.
`default_nettype none
`include "uv_disparity_line_matcher_macros.svh"
module uv_disparity_line_matcher #(
  parameter int unsigned MAX_U_LINES = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  uvdlm_cmd_if.sink                                   cmd,
  uvdlm_result_if.source                              result,
  input  wire logic                                   cfg_write,
  input  wire logic [uvdlm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [uvdlm_pkg::FIELD_W-1:0]          cfg_data
);
  import uvdlm_pkg::*;

  localparam int unsigned AW = (MAX_U_LINES > 1) ? $clog2(MAX_U_LINES) : 1;
  localparam int unsigned CW = $clog2(MAX_U_LINES + 1);
  localparam logic [CW-1:0] TABLE_FULL = CW'(MAX_U_LINES);
  localparam logic [MATCH_CNT_W-1:0] LAST_MATCH = MATCH_CNT_W'(RESULT_LIMIT - 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  // Configuration registers.
  logic [FIELD_W-1:0] image_width;
  logic [FIELD_W-1:0] min_disparity;
  logic [FIELD_W-1:0] match_tolerance;

  // Sequencer state.
  state_t             state, state_next;
  logic [CW-1:0]      line_cnt, line_cnt_next;
  logic [CW-1:0]      scan_idx, scan_idx_next;
  logic               rd_vld, rd_vld_next;
  logic [MATCH_CNT_W-1:0] match_cnt, match_cnt_next;

  // The most recent match is held back until the scan knows whether it is
  // the final one, so that last can be set on it.
  logic               pend_vld, pend_vld_next;
  line_t              pend, pend_next;

  // Latched query.
  logic [FIELD_W-1:0] q_disp, q_first, q_second;

  // Output register.
  logic               out_vld, out_vld_next;
  logic               out_found, out_last;
  logic [FIELD_W-1:0] out_left_x, out_top_y, out_right_x, out_bottom_y;

  // Table RAM ports.
  logic               ram_we, ram_re;
  line_t              ram_wdata, ram_rdata;

  logic               cmd_xfer, hit, cur_match, out_free, stall;
  logic               push, push_found, push_last;

  assign cmd_xfer = cmd.valid && cmd.ready;
  assign out_free = !out_vld || result.ready;

  uvdlm_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_U_LINES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (line_cnt[AW-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (scan_idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  uvdlm_match u_match (
    .line_disparity  (ram_rdata.disparity),
    .query_disparity (q_disp),
    .tolerance       (match_tolerance),
    .hit             (hit)
  );

  assign cur_match = (state == ST_SCAN) && rd_vld && hit;
  // A second match cannot be taken while the held one has nowhere to go.
  assign stall     = cur_match && pend_vld && !out_free;

  assign ram_wdata = '{disparity: cmd.disparity, start_col: cmd.first_coord,
                       end_col: cmd.second_coord};
  assign ram_we    = cmd_xfer && (cmd.command == CMD_ADD) && (line_cnt < TABLE_FULL);

  always_comb begin
    state_next     = state;
    line_cnt_next  = line_cnt;
    scan_idx_next  = scan_idx;
    rd_vld_next    = rd_vld;
    match_cnt_next = match_cnt;
    pend_vld_next  = pend_vld;
    pend_next      = pend;
    ram_re         = 1'b0;
    push           = 1'b0;
    push_found     = 1'b0;
    push_last      = 1'b0;

    case (state)
      ST_IDLE: begin
        if (cmd_xfer) begin
          case (cmd.command)
            CMD_CLEAR: begin
              line_cnt_next = '0;
            end
            CMD_ADD: begin
              if (line_cnt < TABLE_FULL) begin
                line_cnt_next = line_cnt + 1'b1;
              end
            end
            CMD_QUERY: begin
              scan_idx_next  = '0;
              rd_vld_next    = 1'b0;
              match_cnt_next = '0;
              pend_vld_next  = 1'b0;
              state_next     = (cmd.disparity >= min_disparity) ? ST_SCAN : ST_FLUSH;
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (!stall) begin
          if (cur_match) begin
            // Release the previously held match as a non-final result.
            if (pend_vld) begin
              push       = 1'b1;
              push_found = 1'b1;
            end
            pend_next      = ram_rdata;
            pend_vld_next  = 1'b1;
            match_cnt_next = match_cnt + 1'b1;
          end
          if (scan_idx < line_cnt) begin
            ram_re        = 1'b1;
            scan_idx_next = scan_idx + 1'b1;
            rd_vld_next   = 1'b1;
          end else begin
            rd_vld_next = 1'b0;
            if (!rd_vld) begin
              state_next = ST_FLUSH;
            end
          end
          // The result limit ends the scan at once.
          if (cur_match && (match_cnt == LAST_MATCH)) begin
            rd_vld_next = 1'b0;
            state_next  = ST_FLUSH;
          end
        end
      end

      ST_FLUSH: begin
        if (out_free) begin
          push          = 1'b1;
          push_found    = pend_vld;
          push_last     = 1'b1;
          pend_vld_next = 1'b0;
          rd_vld_next   = 1'b0;
          state_next    = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign out_vld_next = push ? 1'b1 : (result.ready ? 1'b0 : out_vld);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      line_cnt  <= '0;
      scan_idx  <= '0;
      rd_vld    <= 1'b0;
      match_cnt <= '0;
      pend_vld  <= 1'b0;
      out_vld   <= 1'b0;
    end else begin
      state     <= state_next;
      line_cnt  <= line_cnt_next;
      scan_idx  <= scan_idx_next;
      rd_vld    <= rd_vld_next;
      match_cnt <= match_cnt_next;
      pend_vld  <= pend_vld_next;
      out_vld   <= out_vld_next;
    end
  end

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= IMAGE_WIDTH_RST;
      min_disparity   <= MIN_DISPARITY_RST;
      match_tolerance <= MATCH_TOLERANCE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:     image_width     <= cfg_data;
        REG_MIN_DISPARITY:   min_disparity   <= cfg_data;
        REG_MATCH_TOLERANCE: match_tolerance <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pend <= pend_next;
    if (cmd_xfer && (cmd.command == CMD_QUERY)) begin
      q_disp   <= cmd.disparity;
      q_first  <= cmd.first_coord;
      q_second <= cmd.second_coord;
    end
    if (push) begin
      out_found <= push_found;
      out_last  <= push_last;
      if (push_found) begin
        out_left_x   <= mirror_col(image_width, pend.start_col);
        out_right_x  <= mirror_col(image_width, pend.end_col);
        out_top_y    <= q_second;
        out_bottom_y <= q_first;
      end else begin
        out_left_x   <= '0;
        out_right_x  <= '0;
        out_top_y    <= '0;
        out_bottom_y <= '0;
      end
    end
  end

  assign cmd.ready       = (state == ST_IDLE);
  assign result.valid    = out_vld;
  assign result.found    = out_found;
  assign result.left_x   = out_left_x;
  assign result.top_y    = out_top_y;
  assign result.right_x  = out_right_x;
  assign result.bottom_y = out_bottom_y;
  assign result.last     = out_last;

  // An empty result is always the final one of its query.
  `UVDLM_ASSERT_NOW(a_empty_is_last, result.valid && !result.found, result.last)
  // No table read is in flight while commands are being taken.
  `UVDLM_ASSERT_NOW(a_idle_no_read, cmd.ready, !rd_vld)
  // The line count never passes the table depth.
  `UVDLM_ASSERT_NOW(a_count_bounded, 1'b1, line_cnt <= TABLE_FULL)
  // A stalled scan holds its read position and the held match.
  `UVDLM_ASSERT_NEXT(a_stall_holds, stall, $stable(scan_idx) && pend_vld)

endmodule
`default_nettype wire
